// ===== rtl/core/blg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_pkg: shared constants and helpers for the battery level gauge
// Widths, scale factors, class thresholds and register indexes.
// ----------------------------------------------------------------------------
package blg_pkg;

  localparam int SAMPLES_DEF = 10;   // default group size (1..16)

  localparam int ADC_W   = 12;
  localparam int CHG_W   = 2;
  localparam int SUM_W   = 16;
  localparam int CNT_W   = 4;
  localparam int MV_W    = 16;
  localparam int PCT_W   = 7;
  localparam int CLS_W   = 3;
  localparam int DIVR_W  = 8;

  // 100 * 3300 mV: the product carries the percent scale from the start
  localparam int REF_SCALE = 330000;
  localparam int ADC_FULL  = 4095;
  localparam int DIV_UNITS = 16;
  localparam int PCT_FULL  = 100;

  localparam int K_W     = 27;               // REF_SCALE * divider
  localparam int PROD_W  = SUM_W + K_W;      // 100 * numerator
  localparam int DEN_W   = 20;               // group size * 4095 * 16
  localparam int QUOT_W  = 28;               // floor(100 * V)
  localparam int HEAD_W  = PROD_W - QUOT_W;  // product bits below one denominator
  localparam int X_W     = 23;               // percent dividend, < 100 * 65536

  localparam int TH_CRITICAL = 10;
  localparam int TH_LOW      = 25;
  localparam int TH_MEDIUM   = 50;
  localparam int TH_HIGH     = 75;

  localparam logic [CLS_W-1:0] CLS_CRITICAL = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LOW      = 3'd1;
  localparam logic [CLS_W-1:0] CLS_MEDIUM   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_HIGH     = 3'd3;
  localparam logic [CLS_W-1:0] CLS_FULL     = 3'd4;
  localparam logic [CLS_W-1:0] ICON_CHARGING = 3'd5;

  localparam logic [CHG_W-1:0] CHARGE_IN_PROGRESS = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_EN    = 3'd4;

  localparam logic [MV_W-1:0]   EMPTY_MV_RST = 16'd3300;
  localparam logic [MV_W-1:0]   FULL_MV_RST  = 16'd4200;
  localparam logic [DIVR_W-1:0] DIVIDER_RST  = 8'd32;

  function automatic logic [CLS_W-1:0] class_of(input logic [PCT_W-1:0] pct);
    logic [CLS_W-1:0] c;
    if (pct <= PCT_W'(TH_CRITICAL))    c = CLS_CRITICAL;
    else if (pct <= PCT_W'(TH_LOW))    c = CLS_LOW;
    else if (pct <= PCT_W'(TH_MEDIUM)) c = CLS_MEDIUM;
    else if (pct <= PCT_W'(TH_HIGH))   c = CLS_HIGH;
    else                               c = CLS_FULL;
    return c;
  endfunction

endpackage

// ===== rtl/core/blg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_mul: bit-serial multiplier
// Scans the group sum MSB first, one shift-add of the scale per cycle.
// ----------------------------------------------------------------------------
module blg_mul
  import blg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [K_W-1:0]    k,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int MC_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MC_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sh_r, sh_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = MC_W'(SUM_W);
      sh_nxt   = sum;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {acc_r[PROD_W-2:0], 1'b0}
              + (sh_r[SUM_W-1] ? PROD_W'(k) : PROD_W'(0));
      sh_nxt  = {sh_r[SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - MC_W'(1);
      if (cnt_r == MC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/core/blg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_div: bit-serial restoring divider by the group denominator
// One quotient bit per cycle; each bit also feeds an online divide by 100,
// so millivolts come out alongside floor(100 * V).
// ----------------------------------------------------------------------------
module blg_div
  import blg_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SAMPLES_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] prod,
  output logic              done,
  output logic [QUOT_W-1:0] quo,
  output logic              rem_nz,
  output logic [MV_W-1:0]   mv
);

  localparam logic [DEN_W-1:0] DEN =
    DEN_W'(SAMPLES_PER_READING * ADC_FULL * DIV_UNITS);
  localparam int DC_W = $clog2(QUOT_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DC_W-1:0]   cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0] sh_r, sh_nxt;
  logic [PCT_W-1:0]  r100_r, r100_nxt;
  logic [QUOT_W-1:0] mvq_r, mvq_nxt;

  logic [DEN_W:0]    trial;
  logic              qbit;
  logic [PCT_W:0]    u100;
  logic              mbit;

  always_comb begin
    trial = {rem_r, sh_r[QUOT_W-1]};
    qbit  = trial >= {1'b0, DEN};
    u100  = {r100_r, qbit};
    mbit  = u100 >= (PCT_W+1)'(PCT_FULL);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    r100_nxt = r100_r;
    mvq_nxt  = mvq_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DC_W'(QUOT_W);
      // top bits of the product are always below the denominator
      rem_nxt  = DEN_W'(prod[PROD_W-1:QUOT_W]);
      sh_nxt   = prod[QUOT_W-1:0];
      r100_nxt = '0;
      mvq_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = qbit ? DEN_W'(trial - {1'b0, DEN}) : trial[DEN_W-1:0];
      sh_nxt   = {sh_r[QUOT_W-2:0], qbit};
      r100_nxt = mbit ? PCT_W'(u100 - (PCT_W+1)'(PCT_FULL)) : u100[PCT_W-1:0];
      mvq_nxt  = {mvq_r[QUOT_W-2:0], mbit};
      cnt_nxt  = cnt_r - DC_W'(1);
      if (cnt_r == DC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    r100_r <= r100_nxt;
    mvq_r  <= mvq_nxt;
  end

  assign done   = done_r;
  assign quo    = sh_r;
  assign rem_nz = |rem_r;
  assign mv     = (|mvq_r[QUOT_W-1:MV_W]) ? {MV_W{1'b1}} : mvq_r[MV_W-1:0];

endmodule

// ===== rtl/core/blg_pct.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_pct: bit-serial percent divider
// Divides the offset above empty by the span, one of seven bits per cycle.
// ----------------------------------------------------------------------------
module blg_pct
  import blg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [X_W-1:0]   x,
  input  logic [MV_W-1:0]  span,
  output logic             done,
  output logic [PCT_W-1:0] pct
);

  localparam int PC_W = $clog2(PCT_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [PC_W-1:0]  cnt_r, cnt_nxt;
  logic [X_W-1:0]   rem_r, rem_nxt;
  logic [X_W-1:0]   dsh_r, dsh_nxt;
  logic [PCT_W-1:0] q_r, q_nxt;
  logic             fit;

  assign fit = rem_r >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = PC_W'(PCT_W);
      rem_nxt  = x;
      dsh_nxt  = X_W'({span, {(PCT_W-1){1'b0}}});
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = fit ? rem_r - dsh_r : rem_r;
      dsh_nxt = {1'b0, dsh_r[X_W-1:1]};
      q_nxt   = {q_r[PCT_W-2:0], fit};
      cnt_nxt = cnt_r - PC_W'(1);
      if (cnt_r == PC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign pct  = q_r;

endmodule

// ===== rtl/core/battery_level_gauge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_gauge: averaged battery voltage, percent, class and alerts
//
//   port group  direction  request holds
//   in_         in         adc_sample, charge_status
//   out_        out        voltage_mv, percent, level_class, icon_index, alerts
//   cfg_        in         register index, write data (always ready)
//
// A sample that does not close a group is only added to the running sum.
// A closing sample starts a serial multiply, then a serial divide and then a
// percent divide; the result is registered when the percent divide is done.
// in_ready is low during that work, and for a closing sample while an earlier
// result still waits in the output register.
// Reset is synchronous; it clears the sum, count, class and alert latches.
// ----------------------------------------------------------------------------
module battery_level_gauge
  import blg_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SAMPLES_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADC_W-1:0]     in_adc_sample,
  input  logic [CHG_W-1:0]     in_charge_status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MV_W-1:0]      out_voltage_mv,
  output logic [PCT_W-1:0]     out_percent,
  output logic [CLS_W-1:0]     out_level_class,
  output logic [CLS_W-1:0]     out_icon_index,
  output logic                 out_critical_alert,
  output logic                 out_low_alert,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_PCT  = 3'd3;

  logic [2:0]        state_r, state_nxt;

  logic [MV_W-1:0]   empty_r, full_r;
  logic [DIVR_W-1:0] divr_r;
  logic              crit_en_r, low_en_r;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic              crit_lat_r, crit_lat_nxt;
  logic              low_lat_r, low_lat_nxt;
  logic              charging_r, charging_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]   out_mv_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic [CLS_W-1:0]  out_cls_r, out_icon_r;
  logic              out_crit_r, out_low_r;

  logic              in_acc, last;
  logic [SUM_W-1:0]  sum_add;
  logic [K_W-1:0]    k_scale;

  logic              mul_done, div_done, pct_done;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quo;
  logic              rem_nz;
  logic [MV_W-1:0]   mv;
  logic [PCT_W-1:0]  pct_q;

  logic [X_W-1:0]    e100, f100, x_off;
  logic [MV_W-1:0]   span;
  logic              le_empty, ge_full;
  logic [PCT_W-1:0]  pct_fin;
  logic [CLS_W-1:0]  cls_new;
  logic              crit_pulse, low_pulse;

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r   <= EMPTY_MV_RST;
      full_r    <= FULL_MV_RST;
      divr_r    <= DIVIDER_RST;
      crit_en_r <= 1'b1;
      low_en_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EMPTY_MV: empty_r   <= cfg_data;
        REG_FULL_MV:  full_r    <= cfg_data;
        REG_DIVIDER:  divr_r    <= cfg_data[DIVR_W-1:0];
        REG_CRIT_EN:  crit_en_r <= cfg_data[0];
        REG_LOW_EN:   low_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- accumulation ----
  assign last     = cnt_r == CNT_W'(SAMPLES_PER_READING - 1);
  assign in_ready = (state_r == ST_IDLE) && !(out_valid_r && last);
  assign in_acc   = in_valid && in_ready;
  assign sum_add  = sum_r + SUM_W'(in_adc_sample);
  assign k_scale  = K_W'(32'(divr_r) * REF_SCALE);

  // ---- serial datapath ----
  blg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && last),
    .sum   (sum_add),
    .k     (k_scale),
    .done  (mul_done),
    .prod  (prod)
  );

  blg_div #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_done),
    .prod   (prod),
    .done   (div_done),
    .quo    (quo),
    .rem_nz (rem_nz),
    .mv     (mv)
  );

  // quo = floor(100 * V); compares against 100 * limits are exact
  assign e100  = X_W'(empty_r) * X_W'(PCT_FULL);
  assign f100  = X_W'(full_r) * X_W'(PCT_FULL);
  assign x_off = quo[X_W-1:0] - e100;
  assign span  = full_r - empty_r;

  blg_pct u_pct (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_done),
    .x     (x_off),
    .span  (span),
    .done  (pct_done),
    .pct   (pct_q)
  );

  // ---- percent, class and alerts ----
  always_comb begin
    le_empty = (quo < QUOT_W'(e100)) || ((quo == QUOT_W'(e100)) && !rem_nz);
    ge_full  = quo >= QUOT_W'(f100);
    if (le_empty)     pct_fin = '0;
    else if (ge_full) pct_fin = PCT_W'(PCT_FULL);
    else              pct_fin = pct_q;
    cls_new = class_of(pct_fin);

    crit_pulse   = 1'b0;
    low_pulse    = 1'b0;
    crit_lat_nxt = crit_lat_r;
    low_lat_nxt  = low_lat_r;
    cls_nxt      = cls_r;
    if (pct_done && (cls_new != cls_r)) begin
      cls_nxt    = cls_new;
      crit_pulse = (cls_new == CLS_CRITICAL) && crit_en_r && !crit_lat_r;
      low_pulse  = (cls_new == CLS_LOW) && low_en_r && !low_lat_r;
      if (crit_pulse) crit_lat_nxt = 1'b1;
      if (low_pulse)  low_lat_nxt  = 1'b1;
      if (cls_new > CLS_LOW)      low_lat_nxt  = 1'b0;
      if (cls_new > CLS_CRITICAL) crit_lat_nxt = 1'b0;
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    charging_nxt  = charging_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (last) begin
            sum_nxt      = '0;
            cnt_nxt      = '0;
            charging_nxt = in_charge_status == CHARGE_IN_PROGRESS;
            state_nxt    = ST_MUL;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_MUL: begin
        if (mul_done) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_PCT;
      end
      ST_PCT: begin
        if (pct_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      cls_r       <= CLS_CRITICAL;
      crit_lat_r  <= 1'b0;
      low_lat_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      cls_r       <= cls_nxt;
      crit_lat_r  <= crit_lat_nxt;
      low_lat_r   <= low_lat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    charging_r <= charging_nxt;
    if (pct_done) begin
      out_mv_r   <= mv;
      out_pct_r  <= pct_fin;
      out_cls_r  <= cls_new;
      out_icon_r <= charging_r ? ICON_CHARGING : cls_new;
      out_crit_r <= crit_pulse;
      out_low_r  <= low_pulse;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_voltage_mv     = out_mv_r;
  assign out_percent        = out_pct_r;
  assign out_level_class    = out_cls_r;
  assign out_icon_index     = out_icon_r;
  assign out_critical_alert = out_crit_r;
  assign out_low_alert      = out_low_r;

endmodule
